### hw/rtl/abg_pkg.sv
// Package for the adaptive bias / adaptive gain speed loop.
// Holds the shared constants, the item and loop state types and the register map.
// No dependencies.
`timescale 1ns / 1ps

package abg_pkg;

	localparam int DUTY_FULL_SCALE = 1023;
	localparam int PWM_TOP = 511;

	localparam int DutyDivRaw = (DUTY_FULL_SCALE + 1) / (PWM_TOP + 1);
	localparam int DutyDiv = (DutyDivRaw == 0) ? 1 : DutyDivRaw;

	localparam logic [15:0] MAX_PERIOD_RESET = 16'hFFFF;
	localparam logic [16:0] REF_OFFSET = 17'd128;

	localparam int PADDR_W = 3;
	localparam logic REG_MAX_PERIOD = 1'b0;

	typedef struct packed {
		logic [15:0] measured_period;
		logic [15:0] target_value;
		logic        speed_mode;
		logic [9:0]  duty_limit;
		logic [9:0]  applied_duty;
		logic        reseed;
	} item_t;

	typedef struct packed {
		logic signed [9:0] err;
		logic [9:0]        gain;
		logic [10:0]       bias;
	} loop_state_t;

endpackage

### hw/rtl/abg_cfg.sv
// APB-style register file for the speed loop: holds max_period_limit.
// Depends on abg_pkg.
`timescale 1ns / 1ps

module abg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abg_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [15:0]                   max_period_limit
);
	import abg_pkg::*;

	logic [15:0] max_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_period_q <= MAX_PERIOD_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PERIOD)) begin
			max_period_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_PERIOD) ? {16'd0, max_period_q} : 32'd0;
	assign max_period_limit = max_period_q;

endmodule

### hw/rtl/abg_step.sv
// One loop update: reseed, error filter, gain and bias adaptation, drive and compare.
// Pure combinational; depends on abg_pkg.
`timescale 1ns / 1ps

module abg_step (
	input  abg_pkg::item_t       item,
	input  abg_pkg::loop_state_t cur,
	input  logic [15:0]          max_period_limit,
	output abg_pkg::loop_state_t nxt,
	output logic [8:0]           pwm
);
	import abg_pkg::*;

	loop_state_t       seed;
	logic [16:0]       ref_val;
	logic              fast;
	logic              slow;
	logic signed [11:0] err_x;
	logic signed [11:0] sum;
	logic signed [11:0] sum_adj;
	logic signed [11:0] quot;
	logic signed [9:0]  e;
	logic [9:0]        gain_n;
	logic [10:0]       bias_n;
	logic [10:0]       limit_x;
	logic              can_grow;
	logic [11:0]       drive_sum;
	logic [10:0]       drive;
	logic [10:0]       pwm_full;
	logic [8:0]        pwm_drive;
	logic [8:0]        target_sat;

	always_comb begin
		if (item.reseed) begin
			seed.err  = '0;
			seed.gain = item.speed_mode ? 10'd1 : 10'd0;
			seed.bias = item.speed_mode ? {1'b0, item.applied_duty} : 11'd0;
		end else begin
			seed = cur;
		end
	end

	assign ref_val = item.speed_mode ? {1'b0, item.target_value}
	                                 : ({1'b0, max_period_limit} + REF_OFFSET);
	assign fast = !item.speed_mode && (item.measured_period < max_period_limit);
	assign slow = ref_val < {1'b0, item.measured_period};

	// (3*err +- 256) / 4, truncated toward zero
	assign err_x   = {{2{seed.err[9]}}, seed.err};
	assign sum     = (err_x <<< 1) + err_x + (slow ? -12'sd256 : 12'sd256);
	assign sum_adj = sum + ((sum < 12'sd0) ? 12'sd3 : 12'sd0);
	assign quot    = sum_adj >>> 2;
	assign e       = quot[9:0];

	assign can_grow = seed.gain < {1'b0, item.applied_duty[9:1]};
	assign limit_x  = {1'b0, item.duty_limit};

	always_comb begin
		if (e < -10'sd192 || e > 10'sd192) begin
			gain_n = can_grow ? seed.gain + 10'd4 : seed.gain;
		end else if (e < -10'sd128 || e > 10'sd128) begin
			gain_n = can_grow ? seed.gain + 10'd2 : seed.gain;
		end else begin
			gain_n = (seed.gain <= 10'd2) ? 10'd1 : seed.gain - 10'd2;
		end
	end

	always_comb begin
		priority if (e < -10'sd253) begin
			bias_n = ((seed.bias + 11'd6) > limit_x) ? limit_x : seed.bias + 11'd6;
		end else if (e < -10'sd192) begin
			bias_n = (seed.bias < limit_x) ? seed.bias + 11'd1 : seed.bias;
		end else if (e > 10'sd253) begin
			bias_n = (seed.bias < 11'd7) ? 11'd1 : seed.bias - 11'd6;
		end else if (e > 10'sd192) begin
			bias_n = (seed.bias > 11'd1) ? seed.bias - 11'd1 : seed.bias;
		end else begin
			bias_n = seed.bias;
		end
	end

	assign drive_sum = {1'b0, bias_n} + {2'b00, gain_n};

	always_comb begin
		if (slow) begin
			drive = (drive_sum > {1'b0, limit_x}) ? limit_x : drive_sum[10:0];
		end else begin
			drive = (bias_n > {1'b0, gain_n}) ? bias_n - {1'b0, gain_n} : 11'd0;
		end
	end

	assign pwm_full   = 11'(drive / DutyDiv);
	assign pwm_drive  = (pwm_full > 11'(PWM_TOP)) ? 9'(PWM_TOP) : pwm_full[8:0];
	assign target_sat = (item.target_value > 16'(PWM_TOP)) ? 9'(PWM_TOP)
	                                                       : item.target_value[8:0];

	always_comb begin
		if (fast) begin
			nxt = seed;
			pwm = target_sat;
		end else begin
			nxt.err  = e;
			nxt.gain = gain_n;
			nxt.bias = bias_n;
			if (!item.speed_mode && ({7'd0, pwm_drive} <= item.target_value)) begin
				pwm = target_sat;
			end else begin
				pwm = pwm_drive;
			end
		end
	end

endmodule

### hw/rtl/adaptive_bias_gain_speed_loop_core.sv
// Top level of the adaptive bias / adaptive gain speed loop.
// Input register, loop state, result register; uses abg_cfg, abg_step and abg_pkg.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+-------------------------------------------
//   item      | item_valid / item_stall       | measured_period .. reseed
//   result    | result_valid / result_stall   | pwm_compare, error_level, gain/bias_level
//   config    | psel penable pwrite pready    | paddr, pwdata, prdata
//
// One word per cycle sustained while result_stall is low.
// The loop update is one combinational pass from the input register into the loop
// state and the result register. Reset clears the loop state, both valid flags and
// sets max_period_limit to 65535. A stalled result holds the input register and,
// once that is full, stalls the item side.
`timescale 1ns / 1ps

module adaptive_bias_gain_speed_loop_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [15:0]                 measured_period,
	input  logic [15:0]                 target_value,
	input  logic                        speed_mode,
	input  logic [9:0]                  duty_limit,
	input  logic [9:0]                  applied_duty,
	input  logic                        reseed,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [8:0]                  pwm_compare,
	output logic signed [9:0]           error_level,
	output logic [9:0]                  gain_level,
	output logic [9:0]                  bias_level,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import abg_pkg::*;

	logic [15:0] max_period_limit;
	item_t       item_s1;
	logic        valid_s1;
	logic        valid_s2;
	loop_state_t state_q;
	loop_state_t state_nxt;
	logic [8:0]  pwm_nxt;
	logic [8:0]  pwm_s2;
	logic signed [9:0] err_s2;
	logic [9:0]  gain_s2;
	logic [9:0]  bias_s2;
	logic        advance;
	logic        take;

	abg_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.max_period_limit (max_period_limit)
	);

	abg_step u_step (
		.item             (item_s1),
		.cur              (state_q),
		.max_period_limit (max_period_limit),
		.nxt              (state_nxt),
		.pwm              (pwm_nxt)
	);

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.measured_period <= measured_period;
			item_s1.target_value    <= target_value;
			item_s1.speed_mode      <= speed_mode;
			item_s1.duty_limit      <= duty_limit;
			item_s1.applied_duty    <= applied_duty;
			item_s1.reseed          <= reseed;
		end
		if (advance) begin
			pwm_s2  <= pwm_nxt;
			err_s2  <= state_nxt.err;
			gain_s2 <= state_nxt.gain;
			bias_s2 <= state_nxt.bias[9:0];
		end
	end

	assign result_valid = valid_s2;
	assign pwm_compare  = pwm_s2;
	assign error_level  = err_s2;
	assign gain_level   = gain_s2;
	assign bias_level   = bias_s2;

endmodule
